@@ rtl/stmc_pkg.sv @@
package stmc_pkg;

    // Field widths
    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 10;
    localparam int unsigned HITS_W = 32;

    // Saturation point of the hit counter
    localparam logic [HITS_W-1:0] HIT_MAX = {HITS_W{1'b1}};

    // Operation codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_COMPARE,
        ST_SEARCH
    } t_state;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic shift_en;   // sorted insert: shift the suffix right by one
        logic cmp_en;     // capture equal / less-than flags for a query
    } t_cell_ctrl;

endpackage

@@ rtl/sorted_table_membership_count.sv @@
// Channel   Direction  Transfer when          Ports
// -------   ---------  --------------------   ----------------------------------------
// command   in         start && !busy         i_operation, i_value
// result    out        o_valid (one cycle)    o_found, o_position, o_hit_count,
//                                             o_overflow
//
// Clear completes in the accept cycle; insert, unless the table is full, then
// moves to the shift state, where the cell row shifts. A query passes through
// the compare state in the cells, then the probe sequencer runs one
// binary-search probe per cycle; the result strobes the cycle after the last probe.
// Synchronous active-low reset empties the table and zeroes count and flag.
// The receiver cannot stall; busy holds off new commands while one is in work.
module sorted_table_membership_count #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [stmc_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    output logic                                o_found,
    output logic [stmc_pkg::POS_W-1:0]          o_position,
    output logic [stmc_pkg::HITS_W-1:0]         o_hit_count,
    output logic                                o_overflow
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PW = (IW > stmc_pkg::POS_W) ? IW : stmc_pkg::POS_W;

    stmc_pkg::t_state                   r_state;
    stmc_pkg::t_state                   n_state;
    logic signed [stmc_pkg::DATA_W-1:0] r_value;
    logic signed [stmc_pkg::DATA_W-1:0] n_value;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic [stmc_pkg::HITS_W-1:0]        r_hits;
    logic [stmc_pkg::HITS_W-1:0]        n_hits;
    logic                               r_overflow;
    logic                               n_overflow;
    logic [CW-1:0]                      r_left;
    logic [CW-1:0]                      n_left;
    logic [CW-1:0]                      r_right;
    logic [CW-1:0]                      n_right;
    logic                               r_valid;
    logic                               n_valid;
    logic                               r_found;
    logic                               n_found;
    logic [stmc_pkg::POS_W-1:0]         r_position;
    logic [stmc_pkg::POS_W-1:0]         n_position;

    stmc_pkg::t_cell_ctrl               w_ctrl;
    logic signed [stmc_pkg::DATA_W-1:0] w_chain_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]             w_chain_vlt;
    logic [TABLE_DEPTH-1:0]             w_flag_eq;
    logic [TABLE_DEPTH-1:0]             w_flag_vlt;

    logic                               w_accept;
    logic                               w_full;
    logic [CW:0]                        w_mid_sum;
    logic [CW-1:0]                      w_mid_full;
    logic [IW-1:0]                      w_mid;
    logic [PW-1:0]                      w_mid_ext;
    logic                               w_probe_eq;
    logic                               w_probe_vlt;

    // Row of cells, each holding one sorted entry
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic signed [stmc_pkg::DATA_W-1:0] w_prev_value;
        logic                               w_prev_vlt;
        if (g == 0) begin : g_first
            assign w_prev_value = '0;
            assign w_prev_vlt   = 1'b0;
        end else begin : g_rest
            assign w_prev_value = w_chain_value[g-1];
            assign w_prev_vlt   = w_chain_vlt[g-1];
        end
        stmc_cell #(
            .INDEX (g),
            .CNT_W (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_value      (r_value),
            .i_count      (r_count),
            .i_prev_value (w_prev_value),
            .i_prev_vlt   (w_prev_vlt),
            .o_value      (w_chain_value[g]),
            .o_vlt        (w_chain_vlt[g]),
            .o_flag_eq    (w_flag_eq[g]),
            .o_flag_vlt   (w_flag_vlt[g])
        );
    end

    assign w_accept = start && (r_state == stmc_pkg::ST_IDLE);
    assign w_full   = (r_count == CW'(TABLE_DEPTH));

    // Probe index of the binary search
    assign w_mid_sum   = {1'b0, r_left} + {1'b0, r_right};
    assign w_mid_full  = w_mid_sum[CW:1];
    assign w_mid       = w_mid_full[IW-1:0];
    assign w_mid_ext   = PW'(w_mid);
    assign w_probe_eq  = w_flag_eq[w_mid];
    assign w_probe_vlt = w_flag_vlt[w_mid];

    // State register and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= stmc_pkg::ST_IDLE;
            r_count    <= '0;
            r_hits     <= '0;
            r_overflow <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_hits     <= n_hits;
            r_overflow <= n_overflow;
            r_valid    <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_left     <= n_left;
        r_right    <= n_right;
        r_found    <= n_found;
        r_position <= n_position;
    end

    // Next state and outputs of the sequencer
    always_comb begin
        n_state         = r_state;
        n_value         = r_value;
        n_count         = r_count;
        n_hits          = r_hits;
        n_overflow      = r_overflow;
        n_left          = r_left;
        n_right         = r_right;
        n_valid         = 1'b0;
        n_found         = r_found;
        n_position      = r_position;
        w_ctrl.shift_en = 1'b0;
        w_ctrl.cmp_en   = 1'b0;

        case (r_state)
            stmc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_value = i_value;
                    case (stmc_pkg::t_op'(i_operation))
                        stmc_pkg::OP_CLEAR: begin
                            n_count    = '0;
                            n_hits     = '0;
                            n_overflow = 1'b0;
                        end
                        stmc_pkg::OP_INSERT: begin
                            if (w_full) begin
                                n_overflow = 1'b1;
                            end else begin
                                n_state = stmc_pkg::ST_SHIFT;
                            end
                        end
                        stmc_pkg::OP_QUERY: begin
                            n_state = stmc_pkg::ST_COMPARE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stmc_pkg::ST_SHIFT: begin
                w_ctrl.shift_en = 1'b1;
                n_count         = r_count + CW'(1);
                n_state         = stmc_pkg::ST_IDLE;
            end
            stmc_pkg::ST_COMPARE: begin
                w_ctrl.cmp_en = 1'b1;
                n_left        = '0;
                n_right       = r_count;
                n_state       = stmc_pkg::ST_SEARCH;
            end
            stmc_pkg::ST_SEARCH: begin
                if (r_left >= r_right) begin
                    // range empty: not found
                    n_found    = 1'b0;
                    n_position = '0;
                    n_valid    = 1'b1;
                    n_state    = stmc_pkg::ST_IDLE;
                end else if (w_probe_eq) begin
                    n_found    = 1'b1;
                    n_position = w_mid_ext[stmc_pkg::POS_W-1:0];
                    n_valid    = 1'b1;
                    n_state    = stmc_pkg::ST_IDLE;
                    if (r_hits != stmc_pkg::HIT_MAX) begin
                        n_hits = r_hits + stmc_pkg::HITS_W'(1);
                    end
                end else if (!w_probe_vlt) begin
                    // probe below the value: search upper half
                    n_left = w_mid_full + CW'(1);
                end else begin
                    n_right = w_mid_full;
                end
            end
            default: begin
                n_state = stmc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != stmc_pkg::ST_IDLE);
    assign o_valid     = r_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_hit_count = r_hits;
    assign o_overflow  = r_overflow;

    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A result only follows a search step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == stmc_pkg::ST_SEARCH))
        else $error("result strobe without a search");

    // Search window stays ordered and inside the table
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stmc_pkg::ST_SEARCH) |-> (r_left <= r_right + CW'(0)) &&
        (r_right <= r_count))
        else $error("search window out of order");

    // A found result carries a nonzero hit count
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_hit_count != '0))
        else $error("hit reported with zero count");

    // Clear empties the table and zeroes count and flag
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_operation == stmc_pkg::OP_CLEAR)) |=>
        ((r_count == '0) && (r_hits == '0) && !r_overflow))
        else $error("clear did not empty the table");

endmodule

@@ rtl/stmc_cell.sv @@
module stmc_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 11
) (
    input  logic                                i_clk,
    input  stmc_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [stmc_pkg::DATA_W-1:0]  i_value,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic signed [stmc_pkg::DATA_W-1:0]  i_prev_value,
    input  logic                                i_prev_vlt,
    output logic signed [stmc_pkg::DATA_W-1:0]  o_value,
    output logic                                o_vlt,
    output logic                                o_flag_eq,
    output logic                                o_flag_vlt
);

    logic signed [stmc_pkg::DATA_W-1:0] r_entry;
    logic signed [stmc_pkg::DATA_W-1:0] n_entry;
    logic                               r_flag_eq;
    logic                               r_flag_vlt;
    logic                               w_vlt;
    logic                               w_eq;
    logic                               w_in_use;
    logic                               w_at_end;

    // Local compare against the broadcast value
    assign w_vlt    = (i_value < r_entry);
    assign w_eq     = (i_value == r_entry);
    assign w_in_use = (i_count > CNT_W'(INDEX));
    assign w_at_end = (i_count == CNT_W'(INDEX));

    // Sorted insert: cells past the slot take the left neighbor,
    // the slot cell takes the new value (after any equal entries)
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift_en && (w_in_use || w_at_end)) begin
            if (i_prev_vlt) begin
                n_entry = i_prev_value;
            end else if (w_at_end || w_vlt) begin
                n_entry = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctrl.cmp_en) begin
            r_flag_eq  <= w_eq;
            r_flag_vlt <= w_vlt;
        end
    end

    assign o_value    = r_entry;
    assign o_vlt      = w_vlt;
    assign o_flag_eq  = r_flag_eq;
    assign o_flag_vlt = r_flag_vlt;

endmodule
